// ----- sv/bb3_pkg.sv -----
// Shared constants, types and codes of the 3x3 RGB box blur.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = FH_W;
  localparam int TOTAL_W    = ADDR_W + FH_W;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int RAM_W      = 2 * PIX_W;
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 12;
  localparam int RECIP_SH   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FH_W;

  localparam logic [RECIP_W-1:0]   RECIP_NINE = 12'd3641;
  localparam logic [FW_W-1:0]      FW_RESET   = 11'd640;
  localparam logic [FH_W-1:0]      FH_RESET   = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    SRC_WIN,
    SRC_MEAN,
    SRC_OLDER_LAST,
    SRC_NEWER
  } px_src_t;

  typedef struct packed {
    logic              has_res;
    logic              wr;
    logic              last;
    px_src_t           src;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  pix;
  } issue_t;

endpackage

// ----- sv/bb3_ram.sv -----
// Generic RAM: one write port, two registered read ports sharing one read enable.
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_a_r <= mem_r[raddr_a];
      rd_data_b_r <= mem_r[raddr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ----- sv/bb3_issue.sv -----
// Issue stage: configuration registers, frame counters and line buffer read addressing.
module bb3_issue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,
  input  logic [bb3_pkg::PIX_W-1:0]        in_tdata,
  input  logic                             pipe_free,
  output logic                             accept,
  output bb3_pkg::issue_t                  iss,
  output logic [bb3_pkg::ADDR_W-1:0]       rd_addr_a,
  output logic [bb3_pkg::ADDR_W-1:0]       rd_addr_b
);
  import bb3_pkg::*;

  localparam int OSUM_W = TOTAL_W + 1;

  logic [FW_W-1:0]    frame_width_r, frame_width_nxt;
  logic [FH_W-1:0]    frame_height_r, frame_height_nxt;
  logic [TOTAL_W-1:0] total_r;
  logic               hold_r;
  logic [ADDR_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [TOTAL_W-1:0] out_idx_r, out_idx_nxt;

  logic [FW_W-1:0]    eff_w;
  logic [FW_W-1:0]    w_last;
  logic [FH_W-1:0]    eff_h;
  logic               draining;
  logic [OSUM_W-1:0]  o_plus_w;
  logic [OSUM_W-1:0]  tail_off;
  logic               tail;
  logic [ADDR_W-1:0]  tail_col;
  logic [OSUM_W-1:0]  o_inc;
  logic               is_last;
  logic [FW_W-1:0]    col_inc;
  logic [ROW_W-1:0]   row_inc;

  assign cfg_ready = 1'b1;
  assign in_tready = !hold_r && pipe_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    eff_w = frame_width_r;
    if (frame_width_r == '0) begin
      eff_w = FW_W'(1);
    end else if (frame_width_r > FW_W'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end
    eff_h = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
    w_last   = eff_w - FW_W'(1);
    draining = in_row_r >= eff_h;
    o_plus_w = {1'b0, out_idx_r} + OSUM_W'(eff_w);
    tail     = o_plus_w >= {1'b0, total_r};
    tail_off = o_plus_w - {1'b0, total_r};
    if (tail_off > OSUM_W'(w_last)) begin
      tail_col = w_last[ADDR_W-1:0];
    end else begin
      tail_col = tail_off[ADDR_W-1:0];
    end
    o_inc   = {1'b0, out_idx_r} + OSUM_W'(1);
    is_last = o_inc >= {1'b0, total_r};
    col_inc = FW_W'(in_col_r) + FW_W'(1);
    row_inc = in_row_r + ROW_W'(1);
  end

  always_comb begin
    iss         = '0;
    iss.src     = SRC_WIN;
    iss.pix     = in_tdata;
    iss.wr_addr = in_col_r;
    rd_addr_a   = in_col_r;
    rd_addr_b   = w_last[ADDR_W-1:0];
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_idx_nxt = out_idx_r;
    if (in_tuser) begin
      rd_addr_a = tail_col;
      if (draining) begin
        iss.has_res = 1'b1;
        iss.last    = is_last;
        iss.src     = tail ? SRC_NEWER : SRC_OLDER_LAST;
        if (is_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_idx_nxt = '0;
        end else begin
          out_idx_nxt = o_inc[TOTAL_W-1:0];
        end
      end
    end else if (!draining) begin
      iss.wr      = 1'b1;
      iss.has_res = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
      if (in_col_r == '0) begin
        iss.src = SRC_OLDER_LAST;
      end else if ((in_row_r >= ROW_W'(2)) && (in_col_r >= ADDR_W'(2))) begin
        iss.src = SRC_MEAN;
      end
      if (iss.has_res) begin
        out_idx_nxt = o_inc[TOTAL_W-1:0];
      end
      if (col_inc >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = row_inc;
      end else begin
        in_col_nxt = col_inc[ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TOTAL_W'(eff_w) * TOTAL_W'(eff_h);
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
      hold_r         <= 1'b1;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_idx_r      <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      hold_r         <= cfg_valid;
      if (accept) begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_idx_r <= out_idx_nxt;
      end
    end
  end

endmodule

// ----- sv/bb3_pipe.sv -----
// Read stage: line buffer forwarding, 3x3 window, mean and output register.
module bb3_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  bb3_pkg::issue_t             iss,
  input  logic [bb3_pkg::ADDR_W-1:0]  rd_addr_a,
  input  logic [bb3_pkg::ADDR_W-1:0]  rd_addr_b,
  input  logic [bb3_pkg::RAM_W-1:0]   ram_qa,
  input  logic [bb3_pkg::RAM_W-1:0]   ram_qb,
  output logic                        pipe_free,
  output logic                        ram_we,
  output logic [bb3_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [bb3_pkg::RAM_W-1:0]   ram_wdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bb3_pkg::PIX_W-1:0]   out_tdata,
  output logic                        out_tlast
);
  import bb3_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;

  logic              s1_v_r;
  issue_t            s1_r;
  logic              fwd_a_r, fwd_b_r;
  logic [RAM_W-1:0]  fwd_data_r;
  logic [PIX_W-1:0]  win_r [6];
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  logic              s1_done;
  logic [RAM_W-1:0]  rd_a, rd_b;
  logic [PIX_W-1:0]  top_px, mid_px, older_last;
  logic [PIX_W-1:0]  nb [9];
  logic [SUM_W-1:0]  sum [3];
  logic [PROD_W-1:0] prod [3];
  logic [PIX_W-1:0]  mean_px;
  logic [PIX_W-1:0]  res_px;

  assign s1_done   = s1_v_r && (!s1_r.has_res || !out_valid_r || out_tready);
  assign pipe_free = !s1_v_r || s1_done;

  assign rd_a       = fwd_a_r ? fwd_data_r : ram_qa;
  assign rd_b       = fwd_b_r ? fwd_data_r : ram_qb;
  assign top_px     = rd_a[RAM_W-1:PIX_W];
  assign mid_px     = rd_a[PIX_W-1:0];
  assign older_last = rd_b[RAM_W-1:PIX_W];

  assign ram_we    = s1_done && s1_r.wr;
  assign ram_waddr = s1_r.wr_addr;
  assign ram_wdata = {mid_px, s1_r.pix};

  always_comb begin
    nb[0] = win_r[0];
    nb[1] = win_r[1];
    nb[2] = win_r[2];
    nb[3] = win_r[3];
    nb[4] = win_r[4];
    nb[5] = win_r[5];
    nb[6] = top_px;
    nb[7] = mid_px;
    nb[8] = s1_r.pix;
    for (int c = 0; c < 3; c++) begin
      sum[c] = ((SUM_W'(nb[0][c*CH_W +: CH_W]) + SUM_W'(nb[1][c*CH_W +: CH_W]))
              + (SUM_W'(nb[2][c*CH_W +: CH_W]) + SUM_W'(nb[3][c*CH_W +: CH_W])))
             + ((SUM_W'(nb[4][c*CH_W +: CH_W]) + SUM_W'(nb[5][c*CH_W +: CH_W]))
              + (SUM_W'(nb[6][c*CH_W +: CH_W]) + SUM_W'(nb[7][c*CH_W +: CH_W])))
             + SUM_W'(nb[8][c*CH_W +: CH_W]);
      prod[c] = PROD_W'(sum[c]) * PROD_W'(RECIP_NINE);
      mean_px[c*CH_W +: CH_W] = prod[c][RECIP_SH +: CH_W];
    end
  end

  always_comb begin
    case (s1_r.src)
      SRC_WIN:        res_px = win_r[4];
      SRC_MEAN:       res_px = mean_px;
      SRC_OLDER_LAST: res_px = older_last;
      SRC_NEWER:      res_px = mid_px;
      default:        res_px = win_r[4];
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r       <= iss;
      fwd_data_r <= ram_wdata;
    end
    if (s1_done && s1_r.has_res) begin
      out_data_r <= res_px;
      out_last_r <= s1_r.last;
    end
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      fwd_a_r     <= 1'b0;
      fwd_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_v_r  <= 1'b1;
        fwd_a_r <= ram_we && (ram_waddr == rd_addr_a);
        fwd_b_r <= ram_we && (ram_waddr == rd_addr_b);
      end else if (s1_done) begin
        s1_v_r <= 1'b0;
      end
      if (ram_we) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_px;
        win_r[4] <= mid_px;
        win_r[5] <= s1_r.pix;
      end
      if (s1_done && s1_r.has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> pipe_free)
    else $error("item issued while the read stage is still occupied");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_r.has_res && out_valid_r && !out_tready |=> s1_v_r && $stable(s1_r))
    else $error("stalled read stage lost its item");

  a_forward_a: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ram_we && (ram_waddr == rd_addr_a)
    |=> fwd_a_r && (fwd_data_r === $past(ram_wdata)))
    else $error("line buffer write not forwarded to the following read");

  a_mean_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && (s1_r.src == SRC_MEAN) |-> s1_r.has_res && s1_r.wr)
    else $error("mean selected for an item that is not a data pixel with a result");

endmodule

// ----- sv/box_blur_3x3_rgb.sv -----
// Top level of the 3x3 RGB box blur with two line buffers in one RAM.
//
//  Group  | Direction | Handshake        | Payload
//  -------+-----------+------------------+---------------------------------------------
//  in_    | input     | tvalid / tready  | tuser: action; tdata: red, green, blue
//  out_   | output    | tvalid / tready  | tlast: frame_last; tdata: red, green, blue
//  cfg_   | input     | valid / ready    | index: register; data: register value
//
// The block takes one beat per clock while in_tready is high; a result is registered
// in the read stage, behind one line buffer read, and then in the output register.
// After reset and in the cycle after each configuration write in_tready is low
// while the frame size product settles. The line buffers need no clearing pass.
// A result held in the output register stalls the read stage only when that stage
// also carries a result; in_tready then falls until the output beat is taken.
module box_blur_3x3_rgb (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,   // [0] action
  input  logic [bb3_pkg::PIX_W-1:0]      in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bb3_pkg::PIX_W-1:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bb3_pkg::*;

  logic              pipe_free;
  logic              accept;
  issue_t            iss;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [RAM_W-1:0]  ram_qa, ram_qb;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;

  bb3_issue u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .pipe_free (pipe_free),
    .accept    (accept),
    .iss       (iss),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b)
  );

  bb3_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk       (clk),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata),
    .re        (accept),
    .raddr_a   (rd_addr_a),
    .raddr_b   (rd_addr_b),
    .rd_data_a (ram_qa),
    .rd_data_b (ram_qb)
  );

  bb3_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .iss        (iss),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .ram_qa     (ram_qa),
    .ram_qb     (ram_qb),
    .pipe_free  (pipe_free),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
